/* hdl/rpc_pkg.sv */
`default_nettype none
package rpc_pkg;

  // Field and datapath widths
  localparam int CW            = 16;               // coordinate width (Q8.8)
  localparam int ANG_W         = 16;               // angle width (Q3.13)
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD         = 14;               // extra fraction bits in the datapath
  localparam int XY_W          = CW + GUARD + 4;   // CORDIC x/y width
  localparam int Z_W           = 35;               // CORDIC angle width, Q2.30 plus headroom
  localparam int DEG_W         = CW + 1;           // degrees, one bit of headroom
  localparam int M_W           = CW + 1;           // signed magnitude after negation
  localparam int KINV_W        = 21;
  localparam int D2R_W         = 32;
  localparam int PZ_W          = DEG_W + D2R_W;    // degrees times pi/180
  localparam int MX_W          = M_W + KINV_W;     // magnitude times 1/K
  localparam int XR_W          = XY_W - (GUARD - 4);
  localparam int PM_W          = XR_W + KINV_W;
  localparam int SAT_W         = XY_W - GUARD;
  localparam int CLAMP_W       = 20;

  // Opcodes
  localparam logic [1:0] OP_RECT  = 2'd0;
  localparam logic [1:0] OP_POLAR = 2'd1;

  typedef enum logic [1:0] {
    MODE_RECT  = 2'd0,
    MODE_POLAR = 2'd1,
    MODE_ERR   = 2'd2
  } rpc_mode_t;

  // Constants
  localparam logic signed [KINV_W-1:0] K_INV_Q20      = KINV_W'(636751);
  localparam logic signed [D2R_W-1:0]  DEG_TO_RAD_Q36 = D2R_W'(64'd1199381129);
  localparam logic signed [Z_W-1:0]    PI_Q30         = Z_W'(64'd3373259426);
  localparam logic signed [DEG_W-1:0]  DEG_TURN       = DEG_W'(23040);
  localparam logic signed [DEG_W-1:0]  DEG_HALF       = DEG_W'(11520);
  localparam logic signed [DEG_W-1:0]  DEG_QUARTER    = DEG_W'(5760);
  localparam logic signed [CLAMP_W-1:0] ANG_LIMIT     = CLAMP_W'(25736);

  // One item as it moves through the pipeline
  typedef struct packed {
    rpc_mode_t               mode;
    logic                    origin;
    logic signed [CW-1:0]    xo;     // rect echo of x
    logic signed [CW-1:0]    yo;     // rect echo of y
    logic [CW-1:0]           mag;    // polar echo of |magnitude|
    logic signed [ANG_W-1:0] ang;    // polar reported angle
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } rpc_item_t;

  // atan(2^-i) in Q2.30, rounded down
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'd843314856;
      1:       v = 32'd497837829;
      2:       v = 32'd263043836;
      3:       v = 32'd133525158;
      4:       v = 32'd67021686;
      5:       v = 32'd33543515;
      6:       v = 32'd16775850;
      7:       v = 32'd8388437;
      8:       v = 32'd4194282;
      9:       v = 32'd2097149;
      default: begin
        if (i <= 30) v = (32'd1 << (30 - i)) - 32'd1;
        else v = 32'd0;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(2 ** (CW - 1) - 1);
    lo = ~hi;
    if (v > hi) return hi[CW-1:0];
    else if (v < lo) return lo[CW-1:0];
    else return v[CW-1:0];
  endfunction

  function automatic logic signed [ANG_W-1:0] clamp_ang(input logic signed [CLAMP_W-1:0] a);
    logic signed [CLAMP_W-1:0] r;
    if (a > ANG_LIMIT) r = ANG_LIMIT;
    else if (a < -ANG_LIMIT) r = -ANG_LIMIT;
    else r = a;
    return r[ANG_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/rpc_pre.sv */
`default_nettype none
module rpc_pre (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_opcode,
  input  logic signed [rpc_pkg::CW-1:0]   in_a,
  input  logic signed [rpc_pkg::CW-1:0]   in_b,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rpc_pkg::rpc_item_t              out_item
);
  import rpc_pkg::*;

  localparam logic signed [PZ_W-1:0] PZ_HALF = PZ_W'(2 ** 11);
  localparam logic signed [MX_W-1:0] PX_HALF = MX_W'(2 ** (19 - GUARD));
  localparam logic signed [PZ_W-1:0] PA_HALF = PZ_W'(2 ** 28);

  // Stage 1: decode, angle reduction, quadrant fold
  rpc_item_t               s1_item_r, s1_item_nxt;
  logic signed [DEG_W-1:0] s1_rc_r, s1_rc_nxt;
  logic signed [DEG_W-1:0] s1_ro_r, s1_ro_nxt;
  logic signed [M_W-1:0]   s1_m_r, s1_m_nxt;
  logic                    s1_v_r;
  // Stage 2: constant multiplies
  rpc_item_t               s2_item_r;
  logic signed [PZ_W-1:0]  s2_pz_r, s2_pz_nxt;
  logic signed [PZ_W-1:0]  s2_pa_r, s2_pa_nxt;
  logic signed [MX_W-1:0]  s2_px_r, s2_px_nxt;
  logic                    s2_v_r;
  // Stage 3: rounding and CORDIC start vector
  rpc_item_t               s3_item_r, s3_item_nxt;
  logic                    s3_v_r;

  logic rdy1, rdy2, rdy3;

  assign rdy3     = !s3_v_r || out_ready;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    logic signed [DEG_W-1:0] bx;
    logic signed [DEG_W-1:0] r;
    logic signed [DEG_W-1:0] ro_t;
    logic signed [XY_W-1:0]  ax;
    logic signed [XY_W-1:0]  ay;
    logic signed [M_W-1:0]   mx;
    s1_item_nxt = '0;
    case (in_opcode)
      OP_RECT:  s1_item_nxt.mode = MODE_RECT;
      OP_POLAR: s1_item_nxt.mode = MODE_POLAR;
      default:  s1_item_nxt.mode = MODE_ERR;
    endcase
    s1_item_nxt.origin = (in_a == '0) && (in_b == '0);
    s1_item_nxt.xo     = in_a;
    s1_item_nxt.yo     = in_b;
    s1_item_nxt.mag    = in_a[CW-1] ? ((~in_a) + {{(CW-1){1'b0}}, 1'b1}) : in_a;

    // left half plane folds over by pi
    ax = {{(XY_W-CW-GUARD){in_a[CW-1]}}, in_a, {GUARD{1'b0}}};
    ay = {{(XY_W-CW-GUARD){in_b[CW-1]}}, in_b, {GUARD{1'b0}}};
    if (in_a[CW-1]) begin
      s1_item_nxt.x = -ax;
      s1_item_nxt.y = -ay;
      s1_item_nxt.z = in_b[CW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      s1_item_nxt.x = ax;
      s1_item_nxt.y = ay;
      s1_item_nxt.z = '0;
    end

    // degrees into (-180,180]; one step covers the whole input range
    bx = DEG_W'(in_b);
    if (bx > DEG_HALF) r = bx - DEG_TURN;
    else if (bx <= -DEG_HALF) r = bx + DEG_TURN;
    else r = bx;

    mx = M_W'(in_a);
    if (r > DEG_QUARTER) begin
      s1_rc_nxt = r - DEG_HALF;
      s1_m_nxt  = -mx;
    end else if (r < -DEG_QUARTER) begin
      s1_rc_nxt = r + DEG_HALF;
      s1_m_nxt  = -mx;
    end else begin
      s1_rc_nxt = r;
      s1_m_nxt  = mx;
    end

    // negative magnitude reports the opposite direction
    ro_t = r + DEG_HALF;
    if (ro_t > DEG_HALF) ro_t = ro_t - DEG_TURN;
    s1_ro_nxt = in_a[CW-1] ? ro_t : r;
  end

  always_comb begin
    s2_pz_nxt = s1_rc_r * DEG_TO_RAD_Q36;
    s2_pa_nxt = s1_ro_r * DEG_TO_RAD_Q36;
    s2_px_nxt = s1_m_r * K_INV_Q20;
  end

  always_comb begin
    logic signed [PZ_W-1:0] pz_q;
    logic signed [PZ_W-1:0] pa_q;
    logic signed [MX_W-1:0] px_q;
    pz_q = (s2_pz_r + PZ_HALF) >>> 12;
    pa_q = (s2_pa_r + PA_HALF) >>> 29;
    px_q = (s2_px_r + PX_HALF) >>> (20 - GUARD);
    s3_item_nxt = s2_item_r;
    if (s2_item_r.mode == MODE_POLAR) begin
      s3_item_nxt.x   = px_q[XY_W-1:0];
      s3_item_nxt.y   = '0;
      s3_item_nxt.z   = pz_q[Z_W-1:0];
      s3_item_nxt.ang = clamp_ang(pa_q[CLAMP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_item_r <= s1_item_nxt;
      s1_rc_r   <= s1_rc_nxt;
      s1_ro_r   <= s1_ro_nxt;
      s1_m_r    <= s1_m_nxt;
    end
    if (rdy2 && s1_v_r) begin
      s2_item_r <= s1_item_r;
      s2_pz_r   <= s2_pz_nxt;
      s2_pa_r   <= s2_pa_nxt;
      s2_px_r   <= s2_px_nxt;
    end
    if (rdy3 && s2_v_r) begin
      s3_item_r <= s3_item_nxt;
    end
  end

  assign out_valid = s3_v_r;
  assign out_item  = s3_item_r;

endmodule
`default_nettype wire

/* hdl/rpc_cordic.sv */
`default_nettype none
module rpc_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpc_pkg::rpc_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rpc_pkg::rpc_item_t out_item
);
  import rpc_pkg::*;

  rpc_item_t                stg_r   [CORDIC_STAGES];
  rpc_item_t                stg_in  [CORDIC_STAGES];
  rpc_item_t                stg_nxt [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] vld_r;
  logic [CORDIC_STAGES-1:0] vld_in;
  wire  [CORDIC_STAGES:0]   rdy;

  assign rdy[CORDIC_STAGES] = out_ready;
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_comb begin
    stg_in[0] = in_item;
    vld_in[0] = in_valid;
    for (int k = 1; k < CORDIC_STAGES; k++) begin
      stg_in[k] = stg_r[k-1];
      vld_in[k] = vld_r[k-1];
    end
  end

  // One micro-rotation per stage: vectoring drives y to 0, rotation drives z to 0
  always_comb begin
    rpc_item_t              cur;
    logic signed [XY_W-1:0] xs, ys, dx, dy;
    logic signed [Z_W-1:0]  zs, at;
    logic                   ccw;
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      cur = stg_in[k];
      xs  = cur.x;
      ys  = cur.y;
      zs  = cur.z;
      dx  = ys >>> k;
      dy  = xs >>> k;
      at  = Z_W'(atan_q30(k));
      ccw = (cur.mode == MODE_POLAR) ? !zs[Z_W-1] : ys[XY_W-1];
      if (ccw) begin
        cur.x = xs - dx;
        cur.y = ys + dy;
        cur.z = zs - at;
      end else begin
        cur.x = xs + dx;
        cur.y = ys - dy;
        cur.z = zs + at;
      end
      stg_nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < CORDIC_STAGES; k++) begin
        if (rdy[k]) vld_r[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      if (rdy[k] && vld_in[k]) stg_r[k] <= stg_nxt[k];
    end
  end

  assign out_valid = vld_r[CORDIC_STAGES-1];
  assign out_item  = stg_r[CORDIC_STAGES-1];

endmodule
`default_nettype wire

/* hdl/rpc_post.sv */
`default_nettype none
module rpc_post (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rpc_pkg::rpc_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rpc_pkg::CW-1:0]     out_x,
  output logic signed [rpc_pkg::CW-1:0]     out_y,
  output logic [rpc_pkg::CW-1:0]            out_mag,
  output logic signed [rpc_pkg::ANG_W-1:0]  out_ang,
  output logic                              out_err
);
  import rpc_pkg::*;

  localparam logic signed [XY_W-1:0] XR_HALF  = XY_W'(2 ** (GUARD - 5));
  localparam logic signed [XY_W-1:0] XY_HALF  = XY_W'(2 ** (GUARD - 1));
  localparam logic signed [Z_W-1:0]  Z_HALF   = Z_W'(2 ** 16);
  localparam logic signed [PM_W-1:0] PM_HALF  = PM_W'(2 ** 23);
  localparam logic signed [PM_W-1:0] MAG_MAX  = PM_W'(2 ** CW - 1);

  // Q1: roundings
  rpc_item_t               q1_item_r;
  logic signed [XR_W-1:0]  q1_xr_r, q1_xr_nxt;
  logic signed [CW-1:0]    q1_px_r, q1_px_nxt;
  logic signed [CW-1:0]    q1_py_r, q1_py_nxt;
  logic signed [ANG_W-1:0] q1_ra_r, q1_ra_nxt;
  logic                    q1_v_r;
  // Q2: gain correction multiply
  rpc_item_t               q2_item_r;
  logic signed [PM_W-1:0]  q2_pm_r, q2_pm_nxt;
  logic signed [CW-1:0]    q2_px_r;
  logic signed [CW-1:0]    q2_py_r;
  logic signed [ANG_W-1:0] q2_ra_r;
  logic                    q2_v_r;
  // Q3: output register
  logic signed [CW-1:0]    q3_x_r, q3_x_nxt;
  logic signed [CW-1:0]    q3_y_r, q3_y_nxt;
  logic [CW-1:0]           q3_mag_r, q3_mag_nxt;
  logic signed [ANG_W-1:0] q3_ang_r, q3_ang_nxt;
  logic                    q3_err_r, q3_err_nxt;
  logic                    q3_v_r;

  logic rdy1, rdy2, rdy3;

  assign rdy3     = !q3_v_r || out_ready;
  assign rdy2     = !q2_v_r || rdy3;
  assign rdy1     = !q1_v_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    logic signed [XY_W-1:0] xr_q, px_q, py_q;
    logic signed [Z_W-1:0]  z_q;
    xr_q = (in_item.x + XR_HALF) >>> (GUARD - 4);
    px_q = (in_item.x + XY_HALF) >>> GUARD;
    py_q = (in_item.y + XY_HALF) >>> GUARD;
    z_q  = (in_item.z + Z_HALF) >>> 17;
    q1_xr_nxt = xr_q[XR_W-1:0];
    q1_px_nxt = sat_coord(px_q[SAT_W-1:0]);
    q1_py_nxt = sat_coord(py_q[SAT_W-1:0]);
    q1_ra_nxt = clamp_ang(CLAMP_W'($signed(z_q[Z_W-18:0])));
  end

  assign q2_pm_nxt = q1_xr_r * K_INV_Q20;

  always_comb begin
    logic signed [PM_W-1:0] t;
    logic [CW-1:0]          mag_sat;
    t = (q2_pm_r + PM_HALF) >>> 24;
    if (t[PM_W-1]) mag_sat = '0;
    else if (t > MAG_MAX) mag_sat = '1;
    else mag_sat = t[CW-1:0];
    q3_x_nxt   = '0;
    q3_y_nxt   = '0;
    q3_mag_nxt = '0;
    q3_ang_nxt = '0;
    q3_err_nxt = 1'b0;
    case (q2_item_r.mode)
      MODE_RECT: begin
        q3_x_nxt   = q2_item_r.xo;
        q3_y_nxt   = q2_item_r.yo;
        q3_mag_nxt = q2_item_r.origin ? '0 : mag_sat;
        q3_ang_nxt = q2_item_r.origin ? '0 : q2_ra_r;
      end
      MODE_POLAR: begin
        q3_x_nxt   = q2_px_r;
        q3_y_nxt   = q2_py_r;
        q3_mag_nxt = q2_item_r.mag;
        q3_ang_nxt = q2_item_r.ang;
      end
      default: q3_err_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
      q2_v_r <= 1'b0;
      q3_v_r <= 1'b0;
    end else begin
      if (rdy1) q1_v_r <= in_valid;
      if (rdy2) q2_v_r <= q1_v_r;
      if (rdy3) q3_v_r <= q2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      q1_item_r <= in_item;
      q1_xr_r   <= q1_xr_nxt;
      q1_px_r   <= q1_px_nxt;
      q1_py_r   <= q1_py_nxt;
      q1_ra_r   <= q1_ra_nxt;
    end
    if (rdy2 && q1_v_r) begin
      q2_item_r <= q1_item_r;
      q2_pm_r   <= q2_pm_nxt;
      q2_px_r   <= q1_px_r;
      q2_py_r   <= q1_py_r;
      q2_ra_r   <= q1_ra_r;
    end
    if (rdy3 && q2_v_r) begin
      q3_x_r   <= q3_x_nxt;
      q3_y_r   <= q3_y_nxt;
      q3_mag_r <= q3_mag_nxt;
      q3_ang_r <= q3_ang_nxt;
      q3_err_r <= q3_err_nxt;
    end
  end

  assign out_valid = q3_v_r;
  assign out_x     = q3_x_r;
  assign out_y     = q3_y_r;
  assign out_mag   = q3_mag_r;
  assign out_ang   = q3_ang_r;
  assign out_err   = q3_err_r;

endmodule
`default_nettype wire

/* hdl/rect_polar_converter.sv */
// Pipeline: 3 prep + 16 CORDIC + 3 post stages from input transfer to result.
// Throughput: one transfer per cycle with out_ready high. Each stage holds one item and
// moves on when the next stage is empty or moving; bubbles close up under backpressure.
// Reset (rst_n low, synchronous) clears only the stage valid bits; no clearing pass,
// the block takes input in the first cycle after reset.
`default_nettype none
module rect_polar_converter (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_opcode,
  input  logic signed [rpc_pkg::CW-1:0]       in_operand_first,
  input  logic signed [rpc_pkg::CW-1:0]       in_operand_second,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rpc_pkg::CW-1:0]       out_x_out,
  output logic signed [rpc_pkg::CW-1:0]       out_y_out,
  output logic [rpc_pkg::CW-1:0]              out_magnitude,
  output logic signed [rpc_pkg::ANG_W-1:0]    out_angle_rad,
  output logic                                out_mode_error
);
  import rpc_pkg::*;

  // Front end: opcode decode, degree reduction to (-180,180], fold of the
  // left half plane (rect) or of angles beyond +-90 degrees (polar), then
  // the pi/180 and 1/K constant multiplies and their roundings.
  rpc_item_t pre_item;
  logic      pre_valid, pre_ready;

  // CORDIC: one register stage per micro-rotation. Mode picks vectoring
  // (sign of y) or rotation (sign of z) per item, so both kinds interleave.
  rpc_item_t cor_item;
  logic      cor_valid, cor_ready;

  rpc_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_a      (in_operand_first),
    .in_b      (in_operand_second),
    .out_valid (pre_valid),
    .out_ready (pre_ready),
    .out_item  (pre_item)
  );

  rpc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pre_valid),
    .in_ready  (pre_ready),
    .in_item   (pre_item),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_item  (cor_item)
  );

  // Back end: gain correction of the vector length, output rounding with
  // saturation, angle clamp to +-pi, and the final per-mode selection.
  // Its last stage is the output register.
  rpc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cor_valid),
    .in_ready  (cor_ready),
    .in_item   (cor_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x_out),
    .out_y     (out_y_out),
    .out_mag   (out_magnitude),
    .out_ang   (out_angle_rad),
    .out_err   (out_mode_error)
  );

endmodule
`default_nettype wire

/* hdl/rpc_checker.sv */
`default_nettype none
module rpc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [rpc_pkg::CW-1:0]      out_x_out,
  input logic signed [rpc_pkg::CW-1:0]      out_y_out,
  input logic [rpc_pkg::CW-1:0]             out_magnitude,
  input logic signed [rpc_pkg::ANG_W-1:0]   out_angle_rad,
  input logic                               out_mode_error
);
  import rpc_pkg::*;

  localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(25736);

  // bad opcode gives an all-zero result
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_error |->
      out_x_out == '0 && out_y_out == '0 && out_magnitude == '0 && out_angle_rad == '0)
    else $error("mode error result not zero");

  // angle always within +-pi
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_rad <= ANG_MAX && out_angle_rad >= -ANG_MAX)
    else $error("angle out of range");

  // a free output side never blocks the input side
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_x_out) && $stable(out_y_out) &&
      $stable(out_magnitude) && $stable(out_angle_rad) && $stable(out_mode_error))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rect_polar_converter rpc_checker u_rpc_checker (.*);
`default_nettype wire

/* tb/rect_polar_converter_test.sv */
`default_nettype none
module rect_polar_converter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rpc_pkg::*;

  // A behavioral CORDIC predictor computes the expected result of every input
  // transfer; a checker compares each output transfer field by field with the
  // oldest pending prediction. Both channels idle at random.

  // Opcodes the block must reject
  localparam logic [1:0] OP_BAD_LO = 2'd2;
  localparam logic [1:0] OP_BAD_HI = 2'd3;

  // Fixed-point constants of the conversion
  localparam longint HALF_TURN_Q30 = 64'sd3373259426;  // pi in Q2.30
  localparam longint KINV          = 64'sd636751;      // 1/K in Q0.20
  localparam longint RAD_PER_DEG   = 64'sd1199381129;  // pi/180 in Q0.36
  localparam longint TURN_DEG      = 23040;            // 360 deg in Q9.6
  localparam longint HALF_DEG      = 11520;
  localparam longint QUARTER_DEG   = 5760;
  localparam longint ANGLE_CAP     = 25736;            // pi in Q3.13
  localparam longint COORD_MAX     = 32767;
  localparam longint COORD_MIN     = -32768;

  // Cycles without any transfer before the run is declared hung. Worst case
  // is a long stall plus a long sender gap plus the pipeline latency.
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [CW-1:0]    x_pos;
    logic signed [CW-1:0]    y_pos;
    logic [CW-1:0]           length;
    logic signed [ANG_W-1:0] heading;
    logic                    bad_mode;
  } conversion_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_opcode = OP_RECT;
  logic signed [CW-1:0]    in_operand_first = '0;
  logic signed [CW-1:0]    in_operand_second = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [CW-1:0]    out_x_out;
  logic signed [CW-1:0]    out_y_out;
  logic [CW-1:0]           out_magnitude;
  logic signed [ANG_W-1:0] out_angle_rad;
  logic                    out_mode_error;

  conversion_t pending_q[$];

  bit idling_on = 1'b1;
  int stall_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int unexpected = 0;
  int leftover = 0;
  int checked = 0;
  int rect_sent = 0;
  int polar_sent = 0;
  int bad_sent = 0;

  rect_polar_converter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_operand_first  (in_operand_first),
    .in_operand_second (in_operand_second),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x_out         (out_x_out),
    .out_y_out         (out_y_out),
    .out_magnitude     (out_magnitude),
    .out_angle_rad     (out_angle_rad),
    .out_mode_error    (out_mode_error)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // atan(2^-i) in Q2.30, rounded down; from 2^-10 down it is 2^(30-i) - 1
  function automatic longint stage_angle(input int i);
    case (i)
      0:  return 843314856;
      1:  return 497837829;
      2:  return 263043836;
      3:  return 133525158;
      4:  return 67021686;
      5:  return 33543515;
      6:  return 16775850;
      7:  return 8388437;
      8:  return 4194282;
      9:  return 2097149;
      default: return (longint'(1) << (30 - i)) - 1;
    endcase
  endfunction

  // round half up, then drop s fraction bits
  function automatic longint round_drop(input longint v, input int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint coord_sat(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint angle_clamp(input longint v);
    if (v > ANGLE_CAP) return ANGLE_CAP;
    if (v < -ANGLE_CAP) return -ANGLE_CAP;
    return v;
  endfunction

  // fold degrees into (-180, 180]; % truncates toward zero
  function automatic longint wrap_degrees(input longint d);
    longint r;
    r = d % TURN_DEG;
    if (r > HALF_DEG) r -= TURN_DEG;
    if (r <= -HALF_DEG) r += TURN_DEG;
    return r;
  endfunction

  function automatic conversion_t convert(input logic [1:0] op,
                                          input logic signed [CW-1:0] first,
                                          input logic signed [CW-1:0] second);
    conversion_t res;
    longint a, b, x, y, z, t, dx, dy, r, rc, m, ro;
    int i;
    res = '0;
    a = first;
    b = second;
    case (op)
      OP_RECT: begin
        res.x_pos = first;
        res.y_pos = second;
        // origin: length and angle stay zero
        if (a != 0 || b != 0) begin
          x = a * (longint'(1) << GUARD);
          y = b * (longint'(1) << GUARD);
          z = 0;
          // left half plane: rotate by pi so vectoring converges
          if (x < 0) begin
            z = (y >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
            x = -x;
            y = -y;
          end
          for (i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
              x += dx; y -= dy; z += stage_angle(i);
            end else begin
              x -= dx; y += dy; z -= stage_angle(i);
            end
          end
          t = round_drop(round_drop(x, GUARD - 4) * KINV, 24);
          if (t < 0) t = 0;
          if (t > 65535) t = 65535;
          res.length  = CW'(t);
          res.heading = ANG_W'(angle_clamp(round_drop(z, 17)));
        end
      end
      OP_POLAR: begin
        r = wrap_degrees(b);
        rc = r;
        m = a;
        // outside +-90 deg: flip by 180 and negate the length
        if (rc > QUARTER_DEG) begin
          rc -= HALF_DEG; m = -m;
        end else if (rc < -QUARTER_DEG) begin
          rc += HALF_DEG; m = -m;
        end
        z = round_drop(rc * RAD_PER_DEG, 12);
        x = round_drop(m * KINV, 20 - GUARD);
        y = 0;
        for (i = 0; i < CORDIC_STAGES; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= stage_angle(i);
          end else begin
            x += dx; y -= dy; z += stage_angle(i);
          end
        end
        res.x_pos  = CW'(coord_sat(round_drop(x, GUARD)));
        res.y_pos  = CW'(coord_sat(round_drop(y, GUARD)));
        res.length = CW'((a < 0) ? -a : a);
        // negative length reports the opposite direction
        ro = (a < 0) ? wrap_degrees(r + HALF_DEG) : r;
        res.heading = ANG_W'(angle_clamp(round_drop(ro * RAD_PER_DEG, 29)));
      end
      default: res.bad_mode = 1'b1;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idling and stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back or short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    if (!idling_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CW'($urandom);
      5, 6:          return CW'(int'($urandom_range(0, 4095)) - 2048);
      7: begin
        case ($urandom_range(0, 3))
          0: return CW'(COORD_MAX);
          1: return CW'(COORD_MIN);
          2: return CW'(1);
          default: return CW'(-1);
        endcase
      end
      8:       return '0;
      default: return CW'(int'($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  // degrees in Q9.6: wide random, near and on the quadrant borders, in range
  function automatic logic signed [CW-1:0] pick_degrees();
    int k;
    k = int'($urandom_range(0, 10)) - 5;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CW'($urandom);
      4, 5:       return CW'(k * QUARTER_DEG + int'($urandom_range(0, 16)) - 8);
      6:          return CW'(k * QUARTER_DEG);
      default:    return CW'(int'($urandom_range(0, 2 * HALF_DEG)) - HALF_DEG);
    endcase
  endfunction

  // Drive one item, hold it until the transfer, record the prediction,
  // then maybe leave a gap. Called right after a rising edge.
  task automatic send_conversion(input logic [1:0] op,
                                 input logic signed [CW-1:0] first,
                                 input logic signed [CW-1:0] second);
    int gap;
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_operand_first  <= first;
    in_operand_second <= second;
    // all inputs move on the rising edge only, so the value at the falling
    // edge is what the next rising edge sees
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_q.push_back(convert(op, first, second));
    case (op)
      OP_RECT:  rect_sent++;
      OP_POLAR: polar_sent++;
      default:  bad_sent++;
    endcase
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) send_conversion(OP_RECT, pick_coord(), pick_coord());
    else if (p < 90) send_conversion(OP_POLAR, pick_coord(), pick_degrees());
    else if (p < 95) send_conversion(OP_BAD_LO, pick_coord(), pick_degrees());
    else send_conversion(OP_BAD_HI, pick_coord(), pick_degrees());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // origin, axes, corners, and the left half plane with y on either side of 0
  task automatic test_rect_directed();
    send_conversion(OP_RECT, 16'sd0, 16'sd0);
    send_conversion(OP_RECT, 16'sd32767, 16'sd0);
    send_conversion(OP_RECT, -16'sd32768, 16'sd0);
    send_conversion(OP_RECT, 16'sd0, 16'sd32767);
    send_conversion(OP_RECT, 16'sd0, -16'sd32768);
    send_conversion(OP_RECT, 16'sd32767, 16'sd32767);
    send_conversion(OP_RECT, -16'sd32768, -16'sd32768);
    send_conversion(OP_RECT, -16'sd256, 16'sd1);
    send_conversion(OP_RECT, -16'sd256, -16'sd1);
    send_conversion(OP_RECT, 16'sd1, -16'sd1);
  endtask

  // quadrant borders, +-180, angles past one turn, negative length, saturation
  task automatic test_polar_directed();
    send_conversion(OP_POLAR, 16'sd256, 16'sd0);
    send_conversion(OP_POLAR, 16'sd256, 16'(QUARTER_DEG));
    send_conversion(OP_POLAR, 16'sd256, 16'(HALF_DEG));
    send_conversion(OP_POLAR, 16'sd256, 16'(-HALF_DEG));
    send_conversion(OP_POLAR, 16'sd256, 16'sd32767);
    send_conversion(OP_POLAR, 16'sd256, -16'sd32768);
    send_conversion(OP_POLAR, -16'sd256, 16'sd2880);
    send_conversion(OP_POLAR, 16'sd32767, 16'sd0);
    send_conversion(OP_POLAR, -16'sd32768, 16'sd0);
    send_conversion(OP_POLAR, -16'sd32768, 16'(HALF_DEG));
    send_conversion(OP_POLAR, 16'sd0, 16'sd1234);
  endtask

  task automatic test_bad_opcodes();
    send_conversion(OP_BAD_LO, 16'sd32767, -16'sd32768);
    send_conversion(OP_BAD_LO, -16'sd1, -16'sd1);
    send_conversion(OP_BAD_HI, -16'sd32768, 16'sd32767);
    send_conversion(OP_BAD_HI, -16'sd1, -16'sd1);
  endtask

  // full rate on both sides: no gaps, no stalls
  task automatic test_streaming(input int count);
    idling_on = 1'b0;
    repeat (count) send_random_item();
    idling_on = 1'b1;
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_item();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checker, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left <= gap_len();
    end
  end

  // sample at the falling edge; a transfer seen here completes at the next
  // rising edge, where pending_q was last updated by the sender
  always @(negedge clk) begin
    conversion_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= MAX_REPORTS)
          $display("unexpected result transfer: x %0d y %0d mag %0d ang %0d err %0b",
                   out_x_out, out_y_out, out_magnitude, out_angle_rad, out_mode_error);
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (out_x_out !== want.x_pos || out_y_out !== want.y_pos ||
            out_magnitude !== want.length || out_angle_rad !== want.heading ||
            out_mode_error !== want.bad_mode) begin
          mismatches++;
          if (mismatches + unexpected <= MAX_REPORTS) begin
            $display("result %0d mismatch: x %0d/%0d y %0d/%0d (expected/actual)",
                     checked, want.x_pos, out_x_out, want.y_pos, out_y_out);
            $display("  mag %0d/%0d ang %0d/%0d err %0b/%0b",
                     want.length, out_magnitude, want.heading, out_angle_rad,
                     want.bad_mode, out_mode_error);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rect_directed();
    test_polar_directed();
    test_bad_opcodes();
    test_streaming(150);
    test_random_mix(1650);

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    // anything arriving now has no prediction and is flagged by the checker
    repeat (DRAIN_CYCLES) @(posedge clk);
    leftover = pending_q.size();

    $display("Checked %0d results: %0d rect-to-polar, %0d polar-to-rect, %0d bad opcode",
             checked, rect_sent, polar_sent, bad_sent);
    $display("Field mismatches %0d, unexpected results %0d, missing results %0d",
             mismatches, unexpected, leftover);
    if (mismatches == 0 && unexpected == 0 && leftover == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hdl/rpc_pkg.sv
hdl/rpc_pre.sv
hdl/rpc_cordic.sv
hdl/rpc_post.sv
hdl/rect_polar_converter.sv
hdl/rpc_checker.sv
tb/rect_polar_converter_test.sv
